FILE: rtl/core/tcp_transfer_time_estimator_top_macros.svh
// Assertion helpers used by the checker file tte_checker.sv.
`ifndef TCP_TRANSFER_TIME_ESTIMATOR_TOP_MACROS_SVH
`define TCP_TRANSFER_TIME_ESTIMATOR_TOP_MACROS_SVH

// Condition in one cycle implies consequence in the next.
`define TTE_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("tte check failed");

// Expression holds at every edge out of reset.
`define TTE_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tte check failed");

`endif

FILE: rtl/core/tte_pkg.sv
`default_nettype none
package tte_pkg;

    localparam logic [31:0] NO_LIMIT     = 32'hffffffff;
    localparam logic [31:0] INF_THRESH   = 32'h7fffffff;
    localparam logic [31:0] SQRT_TOP_BIT = 32'h40000000;
    localparam logic [5:0]  DIV_STEPS    = 6'd32;
    localparam logic [5:0]  SQRT_STEPS   = 6'd16;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_RES_ZERO,
        CMD_FREE,
        CMD_RES_HALF,
        CMD_WIN,
        CMD_DIV_TH,
        CMD_SS,
        CMD_SSP,
        CMD_DIV_LEFT,
        CMD_R,
        CMD_SENT,
        CMD_ALEFT,
        CMD_TOP,
        CMD_SSRT,
        CMD_B2,
        CMD_B3,
        CMD_RES_EARLY,
        CMD_CWTH,
        CMD_SQA,
        CMD_SQRT,
        CMD_CA,
        CMD_CAP,
        CMD_CALEFT,
        CMD_MRT,
        CMD_FIN
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic left_zero;
        logic th_inf;
        logic left_le_pk;
        logic cw_lt_th;
        logic top_lt_th;
        logic left_gt_top;
    } status_t;

    function automatic logic [5:0] bit_len(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        x = v;
        n = 6'd0;
        if (x[31:16] != 16'd0)
        begin
            n = n + 6'd16;
            x = x >> 16;
        end
        if (x[15:8] != 8'd0)
        begin
            n = n + 6'd8;
            x = x >> 8;
        end
        if (x[7:4] != 4'd0)
        begin
            n = n + 6'd4;
            x = x >> 4;
        end
        if (x[3:2] != 2'd0)
        begin
            n = n + 6'd2;
            x = x >> 2;
        end
        if (x[1])
            n = n + 6'd2;
        else if (x[0])
            n = n + 6'd1;
        return n;
    endfunction

    function automatic logic [31:0] ceil_log2(input logic [31:0] v);
        logic [31:0] r;
        if (v > 32'h80000000)
            r = 32'd32;
        else if (v <= 32'd1)
            r = 32'd0;
        else
            r = {26'd0, bit_len(v - 32'd1)};
        return r;
    endfunction

    function automatic logic [31:0] pow_two(input logic [31:0] k);
        logic [31:0] r;
        if (k >= 32'd32)
            r = 32'd0;
        else
            r = 32'd1 << k[4:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tte_in_if.sv
`default_nettype none
interface tte_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] queued_packets;
    logic [19:0] free_window;
    logic [19:0] window;
    logic [30:0] threshold;
    logic [31:0] round_trip;

    modport source (output valid, queued_packets, free_window, window, threshold, round_trip,
                    input ready);
    modport sink (input valid, queued_packets, free_window, window, threshold, round_trip,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tte_out_if.sv
`default_nettype none
interface tte_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] transfer_time;

    modport source (output valid, transfer_time, input ready);
    modport sink (input valid, transfer_time, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tte_dp.sv
`default_nettype none
module tte_dp
    import tte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [19:0] queued_packets,
    input  wire logic [19:0] free_window,
    input  wire logic [19:0] window,
    input  wire logic [30:0] threshold,
    input  wire logic [31:0] round_trip,
    output status_t          status,
    output logic [31:0]      transfer_time
);

    logic [31:0] left_reg, fw_reg, cw_reg, th_reg, rt_reg, tt_reg;
    logic [31:0] ss_reg, pk_reg, top_reg, r_reg, acc_reg;
    logic [31:0] rem_reg, quo_reg, den_reg, bit_reg;
    logic [5:0]  cnt_reg;
    logic        sq_mode_reg;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] two_cw, half_rt;
    logic [32:0] rem_sh;
    logic [31:0] rb;
    logic [31:0] r_calc;

    assign two_cw  = cw_reg << 1;
    assign half_rt = rt_reg >> 1;
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rb      = quo_reg + bit_reg;
    assign r_calc  = ceil_log2(quo_reg + 32'd1);

    // one shared multiplier, result always lands in a register
    always_comb
    begin
        mul_a = cw_reg;
        mul_b = 32'd0;
        case (cmd)
            CMD_SSP:  mul_b = pow_two(ss_reg) - 32'd1;
            CMD_SENT: mul_b = pow_two(r_reg) - 32'd1;
            CMD_TOP:  mul_b = pow_two(ss_reg);
            CMD_SSRT:
            begin
                mul_a = ss_reg;
                mul_b = rt_reg;
            end
            CMD_SQA:
            begin
                mul_a = two_cw + 32'd1;
                mul_b = two_cw + 32'd1;
            end
            CMD_CAP:
            begin
                mul_a = r_reg;
                mul_b = two_cw + r_reg - 32'd1;
            end
            CMD_MRT:
            begin
                mul_a = rt_reg;
                mul_b = r_reg - 32'd1;
            end
            default: mul_b = 32'd0;
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 6'd0;
            sq_mode_reg <= 1'b0;
        end
        else if (cmd == CMD_DIV_TH || cmd == CMD_DIV_LEFT)
        begin
            cnt_reg     <= DIV_STEPS;
            sq_mode_reg <= 1'b0;
        end
        else if (cmd == CMD_SQRT)
        begin
            cnt_reg     <= SQRT_STEPS;
            sq_mode_reg <= 1'b1;
        end
        else if (cnt_reg != 6'd0)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg != 6'd0)
        begin
            if (sq_mode_reg)
            begin
                // one root bit per step
                if (rem_reg >= rb)
                begin
                    rem_reg <= rem_reg - rb;
                    quo_reg <= (quo_reg + (bit_reg << 1)) >> 1;
                end
                else
                    quo_reg <= quo_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                // restoring divide, one quotient bit per step
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= 32'(rem_sh - {1'b0, den_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
        end
        case (cmd)
            CMD_LOAD:
            begin
                left_reg <= {12'd0, queued_packets};
                fw_reg   <= {12'd0, free_window};
                cw_reg   <= {12'd0, window};
                th_reg   <= {1'b0, threshold};
                rt_reg   <= round_trip;
            end
            CMD_RES_ZERO: tt_reg <= 32'd0;
            CMD_FREE: left_reg <= (left_reg > fw_reg) ? left_reg - fw_reg : 32'd0;
            CMD_RES_HALF: tt_reg <= half_rt;
            CMD_WIN:
            begin
                tt_reg <= rt_reg;
                if (two_cw <= th_reg)
                    cw_reg <= two_cw;
                else if (cw_reg < th_reg)
                    cw_reg <= th_reg;
                else
                    cw_reg <= cw_reg + 32'd1;
            end
            CMD_DIV_TH:
            begin
                rem_reg <= 32'd0;
                quo_reg <= th_reg;
                den_reg <= cw_reg;
            end
            CMD_DIV_LEFT:
            begin
                rem_reg <= 32'd0;
                quo_reg <= left_reg;
                den_reg <= cw_reg;
            end
            CMD_SS: ss_reg <= (th_reg == INF_THRESH) ? NO_LIMIT : ceil_log2(quo_reg);
            CMD_SSP: pk_reg <= (th_reg == INF_THRESH) ? NO_LIMIT : prod;
            CMD_R: r_reg <= (r_calc < 32'd1) ? 32'd1 : r_calc;
            CMD_SENT, CMD_SSRT, CMD_CAP, CMD_MRT: acc_reg <= prod;
            CMD_ALEFT: left_reg <= (left_reg > acc_reg) ? left_reg - acc_reg : 32'd0;
            CMD_TOP: top_reg <= prod;
            CMD_B2:
            begin
                tt_reg   <= tt_reg + acc_reg;
                left_reg <= left_reg - pk_reg;
            end
            CMD_B3:
            begin
                left_reg <= left_reg - top_reg;
                tt_reg   <= tt_reg + rt_reg;
                cw_reg   <= th_reg;
            end
            CMD_RES_EARLY: tt_reg <= tt_reg + half_rt;
            CMD_CWTH: cw_reg <= th_reg;
            CMD_SQA: acc_reg <= prod + (left_reg << 3);
            CMD_SQRT:
            begin
                rem_reg <= acc_reg;
                quo_reg <= 32'd0;
                bit_reg <= SQRT_TOP_BIT;
            end
            CMD_CA: r_reg <= (32'd0 - (two_cw - 32'd1) + quo_reg) >> 1;
            CMD_CALEFT:
                left_reg <= (left_reg > (acc_reg >> 1)) ? left_reg - (acc_reg >> 1) : 32'd0;
            CMD_FIN:
                tt_reg <= tt_reg + acc_reg + half_rt + ((left_reg != 32'd0) ? rt_reg : 32'd0);
            default: ;
        endcase
    end

    assign status.busy        = (cnt_reg != 6'd0);
    assign status.left_zero   = (left_reg == 32'd0);
    assign status.th_inf      = (th_reg == INF_THRESH);
    assign status.left_le_pk  = (left_reg <= pk_reg);
    assign status.cw_lt_th    = (cw_reg < th_reg);
    assign status.top_lt_th   = (top_reg < th_reg);
    assign status.left_gt_top = (left_reg > top_reg);
    assign transfer_time      = tt_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tte_ctrl.sv
`default_nettype none
module tte_ctrl
    import tte_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [20:0] {
        S_IDLE   = 21'd1 << 0,
        S_CHK0   = 21'd1 << 1,
        S_CHK1   = 21'd1 << 2,
        S_WIN    = 21'd1 << 3,
        S_WTH    = 21'd1 << 4,
        S_SSP    = 21'd1 << 5,
        S_BR     = 21'd1 << 6,
        S_WL     = 21'd1 << 7,
        S_SENT   = 21'd1 << 8,
        S_ALEFT  = 21'd1 << 9,
        S_SSRT   = 21'd1 << 10,
        S_B2     = 21'd1 << 11,
        S_B3     = 21'd1 << 12,
        S_SQA    = 21'd1 << 13,
        S_SQS    = 21'd1 << 14,
        S_WSQ    = 21'd1 << 15,
        S_CAP    = 21'd1 << 16,
        S_CALEFT = 21'd1 << 17,
        S_MRT    = 21'd1 << 18,
        S_FIN    = 21'd1 << 19,
        S_OUT    = 21'd1 << 20
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_CHK0;
                end
            S_CHK0:
                if (status.left_zero)
                begin
                    cmd        = CMD_RES_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd        = CMD_FREE;
                    state_next = S_CHK1;
                end
            S_CHK1:
                if (status.left_zero)
                begin
                    cmd        = CMD_RES_HALF;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd        = CMD_WIN;
                    state_next = S_WIN;
                end
            S_WIN:
                if (status.th_inf)
                begin
                    cmd        = CMD_SS;
                    state_next = S_SSP;
                end
                else
                begin
                    cmd        = CMD_DIV_TH;
                    state_next = S_WTH;
                end
            S_WTH:
                if (!status.busy)
                begin
                    cmd        = CMD_SS;
                    state_next = S_SSP;
                end
            S_SSP:
            begin
                cmd        = CMD_SSP;
                state_next = S_BR;
            end
            S_BR:
                if (status.left_le_pk)
                begin
                    cmd        = CMD_DIV_LEFT;
                    state_next = S_WL;
                end
                else if (status.cw_lt_th)
                begin
                    cmd        = CMD_TOP;
                    state_next = S_SSRT;
                end
                else
                begin
                    cmd        = CMD_SQA;
                    state_next = S_SQS;
                end
            S_WL:
                if (!status.busy)
                begin
                    cmd        = CMD_R;
                    state_next = S_SENT;
                end
            S_SENT:
            begin
                cmd        = CMD_SENT;
                state_next = S_ALEFT;
            end
            S_ALEFT:
            begin
                cmd        = CMD_ALEFT;
                state_next = S_MRT;
            end
            S_SSRT:
            begin
                cmd        = CMD_SSRT;
                state_next = S_B2;
            end
            S_B2:
            begin
                cmd        = CMD_B2;
                state_next = S_B3;
            end
            S_B3:
                if (!status.top_lt_th)
                begin
                    cmd        = CMD_CWTH;
                    state_next = S_SQA;
                end
                else if (status.left_gt_top)
                begin
                    cmd        = CMD_B3;
                    state_next = S_SQA;
                end
                else
                begin
                    cmd        = CMD_RES_EARLY;
                    state_next = S_OUT;
                end
            S_SQA:
            begin
                cmd        = CMD_SQA;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd        = CMD_SQRT;
                state_next = S_WSQ;
            end
            S_WSQ:
                if (!status.busy)
                begin
                    cmd        = CMD_CA;
                    state_next = S_CAP;
                end
            S_CAP:
            begin
                cmd        = CMD_CAP;
                state_next = S_CALEFT;
            end
            S_CALEFT:
            begin
                cmd        = CMD_CALEFT;
                state_next = S_MRT;
            end
            S_MRT:
            begin
                cmd        = CMD_MRT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd        = CMD_FIN;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/tcp_transfer_time_estimator_top.sv
// TCP transfer time estimator.
// Channel req carries one transaction per subflow query: queued packets, free
// window, window, slow start threshold and smoothed round trip. Channel rsp
// returns one transaction with the estimated transfer time, modulo 2^32.
// Both channels use valid/ready; a transaction moves when both are high.
// One transaction is in flight at a time: req.ready is high only while idle,
// and it rises again the cycle after the rsp transaction completes.
// The work from req accept to rsp valid depends on the branch: an empty queue
// or one that fits the free window needs no divider; slow start may end short
// of the threshold or run with an infinite threshold; congestion avoidance
// runs the 32-step divider and then the 16-step square root; and slow start
// can run the divider twice, on the threshold and then on the queue.
// The shared restoring divider gives one quotient bit per cycle and the square
// root unit one root bit per cycle.
// Reset clears the sequencer to idle; rsp.valid drops and req.ready rises.
// When rsp stalls, the result is held on rsp and no new req is taken until
// the result transaction completes.
`default_nettype none
module tcp_transfer_time_estimator_top
    import tte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tte_in_if.sink    req,
    tte_out_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    // sequencer: handshake and step order
    tte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // registers, shared multiplier, divider and square root
    tte_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .queued_packets (req.queued_packets),
        .free_window    (req.free_window),
        .window         (req.window),
        .threshold      (req.threshold),
        .round_trip     (req.round_trip),
        .status         (status),
        .transfer_time  (rsp.transfer_time)
    );

endmodule
`default_nettype wire

FILE: rtl/core/tte_checker.sv
`default_nettype none
`include "tcp_transfer_time_estimator_top_macros.svh"
module tte_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);

    `TTE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    `TTE_ASSERT_NEXT(a_single_result, out_valid && out_ready, !out_valid)
    `TTE_ASSERT_ALWAYS(a_idle_no_result, !(in_ready && out_valid))
    `TTE_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

endmodule

bind tcp_transfer_time_estimator_top tte_checker u_tte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
);
`default_nettype wire

FILE: dv/tcp_transfer_time_estimator_checker.sv
`timescale 1ns / 1ps
module tcp_transfer_time_estimator_checker
(
    input  wire logic clk,
    input  wire logic rst_n,
    tte_in_if         req,
    tte_out_if        rsp,
    output int        errors,
    output int        pending
);
    import tte_pkg::*;

    logic [31:0] est_q[$];

    function automatic logic [31:0] quot_or_ones(input logic [31:0] n, input logic [31:0] d);
        return (d == 32'd0) ? NO_LIMIT : n / d;
    endfunction

    function automatic logic [31:0] two_to(input logic [31:0] k);
        return (k >= 32'd32) ? 32'd0 : (32'd1 << k[4:0]);
    endfunction

    function automatic logic [31:0] log2_up(input logic [31:0] v);
        logic [31:0] k;
        k = 32'd0;
        if (v > 32'h80000000)
            return 32'd32;
        while (k < 32'd31 && (32'd1 << k) < v)
            k = k + 32'd1;
        return k;
    endfunction

    function automatic logic [31:0] root_floor(input logic [31:0] v);
        logic [31:0] r, rt, b;
        r = v;
        rt = 32'd0;
        b = SQRT_TOP_BIT;
        while (b > r)
            b = b >> 2;
        while (b != 32'd0)
        begin
            if (r >= rt + b)
            begin
                r = r - (rt + b);
                rt = rt + 32'd2 * b;
            end
            rt = rt >> 1;
            b = b >> 2;
        end
        return rt;
    endfunction

    function automatic logic [31:0] transfer_estimate(input logic [31:0] q, input logic [31:0] fw,
        input logic [31:0] w, input logic [31:0] th, input logic [31:0] rt);
        logic [31:0] left, cw, tt, ssr, ssp, r, sent, top, car, cap;
        left = q;
        cw = w;
        tt = 32'd0;
        ssr = NO_LIMIT;
        ssp = NO_LIMIT;
        if (q == 32'd0)
            return 32'd0;
        if (fw > 32'd0)
        begin
            left = (left > fw) ? left - fw : 32'd0;
            if (left == 32'd0)
                return rt / 32'd2;
        end
        tt = tt + rt;
        if (32'd2 * cw <= th)
            cw = cw * 32'd2;
        else if (cw < th)
            cw = th;
        else
            cw = cw + 32'd1;
        if (th != INF_THRESH)
        begin
            ssr = log2_up(quot_or_ones(th, cw));
            ssp = cw * (two_to(ssr) - 32'd1);
        end
        if (left <= ssp)
        begin
            r = log2_up(quot_or_ones(left, cw) + 32'd1);
            if (r < 32'd1)
                r = 32'd1;
            sent = cw * (two_to(r) - 32'd1);
            left = (left > sent) ? left - sent : 32'd0;
            tt = tt + rt * (r - 32'd1) + rt / 32'd2;
            if (left > 32'd0)
                tt = tt + rt;
            return tt;
        end
        if (cw < th)
        begin
            top = cw * two_to(ssr);
            left = left - ssp;
            tt = tt + ssr * rt;
            if (top < th)
            begin
                if (left > top)
                begin
                    left = left - top;
                    tt = tt + rt;
                end
                else
                    return tt + rt / 32'd2;
            end
            cw = th;
        end
        car = (32'd0 - (32'd2 * cw - 32'd1) + root_floor((32'd2 * cw + 32'd1)
              * (32'd2 * cw + 32'd1) + 32'd8 * left)) / 32'd2;
        cap = (car * (32'd2 * cw + (car - 32'd1))) / 32'd2;
        left = (left > cap) ? left - cap : 32'd0;
        tt = tt + rt * (car - 32'd1) + rt / 32'd2;
        if (left > 32'd0)
            tt = tt + rt;
        return tt;
    endfunction

    assign pending = est_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] exp_tt;
        if (!rst_n)
        begin
            errors <= 0;
            est_q.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                est_q.push_back(transfer_estimate({12'd0, req.queued_packets},
                    {12'd0, req.free_window}, {12'd0, req.window}, {1'b0, req.threshold},
                    req.round_trip));
            if (rsp.valid && rsp.ready)
            begin
                if (est_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer_time %h", $time, rsp.transfer_time);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_tt = est_q.pop_front();
                    if (rsp.transfer_time !== exp_tt)
                    begin
                        $display("%0t: transfer_time expected %h actual %h", $time, exp_tt,
                                 rsp.transfer_time);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: dv/tcp_transfer_time_estimator_top_tb.sv
`timescale 1ns / 1ps
module tcp_transfer_time_estimator_top_tb;
    import tte_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;

    tte_in_if  req();
    tte_out_if rsp();

    tcp_transfer_time_estimator_top dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    tcp_transfer_time_estimator_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                                             .errors(errors), .pending(pending));

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Timeout bound: compute plus the random idle gaps on both sides, per
    // transaction, with a wide margin.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("tcp_transfer_time_estimator_top: mismatch");
            $finish;
        end
    end

    // Drain side: draw a stall per result, sometimes none for a stretch.
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    // Send one transaction; hold valid until accepted.
    task automatic send_query(input logic [19:0] q, input logic [19:0] fw,
                              input logic [19:0] w, input logic [30:0] th,
                              input logic [31:0] rt);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.queued_packets <= q;
        req.free_window <= fw;
        req.window <= w;
        req.threshold <= th;
        req.round_trip <= rt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Small values hit the slow start and congestion avoidance branches often.
    function automatic logic [19:0] pick20(input int lo);
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(lo, 16));
            1: return 20'($urandom_range(lo, 4096));
            2: return (20'($urandom) == 0 && lo > 0) ? 20'd1 : 20'($urandom);
            default: return 20'($urandom_range(lo, 300));
        endcase
    endfunction

    initial
    begin
        logic [30:0] th;
        req.valid <= 1'b0;
        req.queued_packets <= '0;
        req.free_window <= '0;
        req.window <= 20'd1;
        req.threshold <= '0;
        req.round_trip <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, fits free window, zero threshold, infinite threshold,
        // extremes of every field, huge log argument and wrapping power.
        send_query(20'd0, 20'd5, 20'd1, 31'd10, 32'hffffffff);
        send_query(20'd5, 20'd5, 20'd1, 31'd10, 32'd1001);
        send_query(20'd4, 20'hfffff, 20'd3, 31'd10, 32'hffffffff);
        send_query(20'd100, 20'd0, 20'd1, 31'd0, 32'd1000);
        send_query(20'd100, 20'd0, 20'd1, 31'h7fffffff, 32'd1000);
        send_query(20'hfffff, 20'd0, 20'd1, 31'h7fffffff, 32'hffffffff);
        send_query(20'hfffff, 20'd0, 20'hfffff, 31'h7ffffffe, 32'd77);
        send_query(20'hfffff, 20'd1, 20'd1, 31'h7ffffffe, 32'd77);
        send_query(20'hfffff, 20'd0, 20'hfffff, 31'd1, 32'd3);
        send_query(20'd1000, 20'd10, 20'd4, 31'd16, 32'd100);
        send_query(20'd1000, 20'd10, 20'd4, 31'd20, 32'd100);
        send_query(20'd50, 20'd0, 20'd8, 31'd8, 32'd100);
        send_query(20'd7, 20'd0, 20'd2, 31'd64, 32'd100);
        send_query(20'd3, 20'd1, 20'd1, 31'd1, 32'd0);
        send_query(20'h55555, 20'haaaaa, 20'h55555, 31'h2aaaaaaa, 32'haaaaaaaa);
        send_query(20'haaaaa, 20'h55555, 20'haaaaa, 31'h55555555, 32'h55555555);

        repeat (1500)
        begin
            case ($urandom_range(0, 5))
                0: th = 31'h7fffffff;
                1: th = 31'($urandom);
                2: th = 31'($urandom_range(0, 64));
                default: th = 31'($urandom_range(0, 5000));
            endcase
            send_query(($urandom_range(0, 20) == 0) ? 20'd0 : pick20(1),
                       ($urandom_range(0, 2) == 0) ? 20'd0 : pick20(0),
                       pick20(1), th, $urandom);
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tcp_transfer_time_estimator_top: match");
        else
            $display("tcp_transfer_time_estimator_top: mismatch");
        $finish;
    end
endmodule
